### rtl/btp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types and constants for the button press tracker.
// ----------------------------------------------------------------------------
package btp_pkg;

  localparam int NUM_BUTTONS_DEF = 20;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int IDX_WIDTH    = 5;
  localparam int TIME_WIDTH   = 16;
  localparam int WINDOW_WIDTH = 16;
  localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd10;

  // Configuration port
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;
  localparam logic REG_WINDOW = 1'b0;  // register index, paddr[2]

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_CLEAR_ALL   = 2'd1,
    OP_CLEAR_FLAGS = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [IDX_WIDTH-1:0] button_index;
    logic                 level;
  } in_item_t;

  typedef struct packed {
    logic                  held;
    logic                  pressed_flag;
    logic                  double_flag;
    logic [TIME_WIDTH-1:0] held_time;
    logic [TIME_WIDTH-1:0] released_time;
    logic                  activity;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;     // latch the input transfer, rewind the clear pointer
    logic update;      // read-modify-write the addressed entry
    logic clear_step;  // clear the entry under the pointer, advance it
    logic emit;        // move the staged result into the output register
  } btp_cmd_t;

  typedef struct packed {
    logic ptr_last;    // clear pointer sits on the last entry
    logic out_free;    // output register can take a result this cycle
  } btp_status_t;

endpackage
`default_nettype wire

### rtl/btp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_ctrl
// Sequencer: accept one transfer, run the update or the clear walk, emit.
// ----------------------------------------------------------------------------
module btp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_op,
  input  wire btp_pkg::btp_status_t status,
  output      btp_pkg::btp_cmd_t    cmd,
  output      logic                 in_stall
);

  btp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      btp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_op) inside
            btp_pkg::OP_CLEAR_ALL, btp_pkg::OP_CLEAR_FLAGS: state_nxt = btp_pkg::ST_CLEAR;
            default: state_nxt = btp_pkg::ST_UPDATE;
          endcase
        end
      end
      btp_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = btp_pkg::ST_EMIT;
      end
      btp_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.ptr_last) begin
          state_nxt = btp_pkg::ST_EMIT;
        end
      end
      btp_pkg::ST_EMIT: begin
        // hold until the output register frees up
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = btp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btp_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/btp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_datapath
// Per-button state table, update logic, clear pointer and output register.
// ----------------------------------------------------------------------------
module btp_datapath #(
  parameter int NUM_BUTTONS = btp_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = btp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire btp_pkg::btp_cmd_t                     cmd,
  output      btp_pkg::btp_status_t                  status,
  input  wire btp_pkg::in_item_t                     in_data,
  input  wire logic [btp_pkg::WINDOW_WIDTH-1:0]      window,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      btp_pkg::out_item_t                    out_data
);

  localparam int PTR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CMP_W = (COUNT_WIDTH > btp_pkg::WINDOW_WIDTH) ?
                         COUNT_WIDTH : btp_pkg::WINDOW_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // entry table
  logic                   held_r   [NUM_BUTTONS];
  logic                   press_r  [NUM_BUTTONS];
  logic                   double_r [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] hcnt_r   [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] rcnt_r   [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] scnt_r   [NUM_BUTTONS];

  // captured transfer
  logic [1:0]                   op_r;
  logic [btp_pkg::IDX_WIDTH-1:0] idx_r;
  logic                         level_r;

  logic [PTR_W-1:0]   ptr_r;
  btp_pkg::out_item_t res_r, res_nxt;
  btp_pkg::out_item_t out_r;
  logic               out_valid_r;

  logic                   sample_ok;
  logic [PTR_W-1:0]       eidx;
  logic                   rising;
  logic [COUNT_WIDTH-1:0] since_inc;
  logic                   held_nxt, press_nxt, double_nxt;
  logic [COUNT_WIDTH-1:0] hcnt_nxt, rcnt_nxt, scnt_nxt;
  logic [CMP_W-1:0]       hcnt_ext, rcnt_ext;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  assign sample_ok = (op_r == btp_pkg::OP_SAMPLE) && (32'(idx_r) < NUM_BUTTONS);
  assign eidx      = idx_r[PTR_W-1:0];

  always_comb begin
    rising     = !held_r[eidx] && level_r;
    since_inc  = sat_inc(scnt_r[eidx]);
    press_nxt  = press_r[eidx] | rising;
    if (held_r[eidx]) begin
      double_nxt = 1'b0;
    end else if (rising) begin
      double_nxt = CMP_W'(since_inc) < CMP_W'(window);
    end else begin
      double_nxt = double_r[eidx];
    end
    scnt_nxt = rising ? '0 : since_inc;
    held_nxt = level_r;
    hcnt_nxt = level_r ? sat_inc(hcnt_r[eidx]) : '0;
    rcnt_nxt = level_r ? '0 : sat_inc(rcnt_r[eidx]);
    hcnt_ext = CMP_W'(hcnt_nxt);
    rcnt_ext = CMP_W'(rcnt_nxt);

    res_nxt = '0;
    if (cmd.update && sample_ok) begin
      res_nxt.held          = held_nxt;
      res_nxt.pressed_flag  = press_nxt;
      res_nxt.double_flag   = double_nxt;
      res_nxt.held_time     = hcnt_ext[btp_pkg::TIME_WIDTH-1:0];
      res_nxt.released_time = rcnt_ext[btp_pkg::TIME_WIDTH-1:0];
      res_nxt.activity      = level_r;
    end
  end

  // entry table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        held_r[i]   <= 1'b0;
        press_r[i]  <= 1'b0;
        double_r[i] <= 1'b0;
        hcnt_r[i]   <= '0;
        rcnt_r[i]   <= '0;
        scnt_r[i]   <= '0;
      end
    end else if (cmd.update && sample_ok) begin
      held_r[eidx]   <= held_nxt;
      press_r[eidx]  <= press_nxt;
      double_r[eidx] <= double_nxt;
      hcnt_r[eidx]   <= hcnt_nxt;
      rcnt_r[eidx]   <= rcnt_nxt;
      scnt_r[eidx]   <= scnt_nxt;
    end else if (cmd.clear_step) begin
      press_r[ptr_r]  <= 1'b0;
      double_r[ptr_r] <= 1'b0;
      if (op_r == btp_pkg::OP_CLEAR_ALL) begin
        held_r[ptr_r] <= 1'b0;
        hcnt_r[ptr_r] <= '0;
        rcnt_r[ptr_r] <= '0;
        scnt_r[ptr_r] <= '0;
      end
    end
  end

  // captured transfer, staged result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.op;
      idx_r   <= in_data.button_index;
      level_r <= in_data.level;
    end
    if (cmd.update || cmd.clear_step) begin
      res_r <= res_nxt;
    end
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  // clear pointer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ptr_r <= '0;
      end else if (cmd.clear_step) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.ptr_last = (ptr_r == PTR_W'(NUM_BUTTONS - 1));
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule
`default_nettype wire

### rtl/button_press_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_tracker_top
// Edge, hold-time and double-press tracker over a table of buttons.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one operation per
//   transfer: sample one button's level, clear all entries, or clear the
//   press and double flags. Every transfer yields exactly one result on the
//   output channel (out_valid / out_stall / out_data); clears, the unused
//   op code and out-of-range buttons give an all-zero result.
//   Timing: a sample passes from the captured transfer through the staged
//   result into the output register, and no new transfer is taken until
//   the result is emitted. A clear walks the table one entry per cycle,
//   from the first entry to the last, before its result is emitted.
//   The result sits in an output register, so the next input transfer is
//   taken while the previous result still waits. When the receiver stalls,
//   out_data holds; the sequencer waits with the next result until the
//   register frees, and in_stall stays high meanwhile.
//   Reset (rst_n low, synchronous) zeros every entry, drops out_valid and
//   sets double_press_window to 10.
//   APB: register 0 (byte address 0) is double_press_window; write it only
//   while the block is idle.
// ----------------------------------------------------------------------------
module button_press_tracker_top #(
  parameter int NUM_BUTTONS = btp_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = btp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire btp_pkg::in_item_t                    in_data,
  // result channel
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      btp_pkg::out_item_t                   out_data,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [btp_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  wire logic [btp_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output      logic [btp_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output      logic                                 pready
);

  btp_pkg::btp_cmd_t    cmd;
  btp_pkg::btp_status_t status;

  logic [btp_pkg::WINDOW_WIDTH-1:0] window_r;
  logic                             reg_sel;

  // Register index sits at paddr[2]; the two low bits are the byte lane.
  assign reg_sel = (paddr[2] == btp_pkg::REG_WINDOW);
  assign pready  = 1'b1;

  // Take the window on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= btp_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      window_r <= pwdata[btp_pkg::WINDOW_WIDTH-1:0];
    end
  end

  // Read back the window; the unused address reads as zero.
  assign prdata = reg_sel ? btp_pkg::CFG_DATA_WIDTH'(window_r) : '0;

  btp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  btp_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .window    (window_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### rtl/btp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_checker
// Port-level checks on the result channel of the button press tracker.
// ----------------------------------------------------------------------------
module btp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire btp_pkg::out_item_t out_data
);

  // reset drops any pending result
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // activity and held both follow the sampled level
  a_activity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.activity == out_data.held)
    else $error("activity differs from held");

  // only one of the two timers can run
  a_timers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.held ? out_data.released_time == '0
                                 : out_data.held_time == '0))
    else $error("held and released timers both nonzero");

  // a double press is always a press
  a_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.double_flag |-> out_data.pressed_flag)
    else $error("double flag without press flag");

endmodule

bind button_press_tracker_top btp_checker u_btp_checker (.*);
`default_nettype wire
